// File: src/assert_macros.svh
// Shared assertion macros for the slot pool checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define TSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tsp_pkg.sv
package tsp_pkg;

   localparam int DATA_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   // per-slot mark
   typedef enum logic [1:0] {
      MARK_FREE  = 2'd0,
      MARK_KIND1 = 2'd1,
      MARK_KIND2 = 2'd2
   } tsp_mark_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } tsp_status_type;

   typedef enum logic {
      ACT_PRODUCE = 1'b0,
      ACT_CONSUME = 1'b1
   } tsp_action_type;

   // classified transaction as it waits in the queue
   typedef struct packed {
      tsp_action_type          action;
      tsp_mark_type            want;
      logic signed [DATA_W-1:0] data;
   } tsp_item_type;

endpackage

// File: src/tsp_if.sv
interface tsp_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic                              kind;
   logic signed [tsp_pkg::DATA_W-1:0] data_in;

   modport source (output valid, action, kind, data_in, input ready);
   modport sink (input valid, action, kind, data_in, output ready);
endinterface

interface tsp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [tsp_pkg::STATUS_W-1:0] status;
   logic        [tsp_pkg::SLOT_W-1:0]   slot;
   logic signed [tsp_pkg::DATA_W-1:0]   data_out;

   modport source (output valid, status, slot, data_out, input ready);
   modport sink (input valid, status, slot, data_out, output ready);
endinterface

// File: src/tsp_front.sv
module tsp_front (
   input  logic                  clock,
   input  logic                  reset,
   tsp_req_if.sink               req_bus,
   output logic                  q_valid,
   input  logic                  q_pop,
   output tsp_pkg::tsp_item_type q_item
);
   import tsp_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   tsp_item_type      queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   tsp_item_type      item_in;
   logic              push;
   logic              pop;

   assign req_bus.ready = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign q_valid       = (count_ff != '0);
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_pop && q_valid;
   assign q_item        = queue_ff[rd_ptr_ff];

   // classify: consume looks for the requested mark, produce fills with it
   always_comb begin
      item_in.action = tsp_action_type'(req_bus.action);
      item_in.want   = req_bus.kind ? MARK_KIND2 : MARK_KIND1;
      item_in.data   = req_bus.data_in;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// File: src/tsp_back.sv
module tsp_back #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  tsp_pkg::tsp_item_type q_item,
   tsp_rsp_if.source             rsp_bus
);
   import tsp_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic {
      S_PICK,
      S_LOAD
   } state_type;

   state_type                state_ff, state_in;
   tsp_mark_type             marks_ff [SLOTS];
   tsp_mark_type             marks_in [SLOTS];
   logic signed [DATA_W-1:0] value_mem [SLOTS];
   logic signed [DATA_W-1:0] rd_data_ff;

   tsp_status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic                     res_take_ff, res_take_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   tsp_status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   tsp_mark_type             want;
   logic                     hit;
   logic [IDX_W-1:0]         hit_idx;
   logic [IDX_W+SLOT_W-1:0]  slot_wide;
   logic                     consume;
   logic                     pop;
   logic                     mem_we;
   logic                     load;

   assign consume = (q_item.action == ACT_CONSUME);
   assign want    = consume ? q_item.want : MARK_FREE;

   // priority encoder, lowest index wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (marks_ff[i] == want) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, hit_idx};
   assign q_pop     = (state_ff == S_PICK);
   assign pop       = q_pop && q_valid;
   assign mem_we    = pop && hit && !consume;
   assign load      = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      marks_in      = marks_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_take_in   = res_take_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_PICK: begin
            if (pop) begin
               if (hit) begin
                  marks_in[hit_idx] = consume ? MARK_FREE : q_item.want;
                  res_status_in     = STATUS_DONE;
                  res_slot_in       = slot_wide[SLOT_W-1:0];
               end else begin
                  res_status_in = consume ? STATUS_EMPTY : STATUS_FULL;
                  res_slot_in   = '0;
               end
               res_take_in = hit && consume;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_data_in   = res_take_ff ? rd_data_ff : DATA_W'(0);
               state_in      = S_PICK;
            end
         end
         default: state_in = S_PICK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PICK;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            marks_ff[i] <= MARK_FREE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         marks_ff     <= marks_in;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_take_ff   <= res_take_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // value store: registered read per pick, write on produce hit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[hit_idx] <= q_item.data;
      end
      if (pop) begin
         rd_data_ff <= value_mem[hit_idx];
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.slot     = rsp_slot_ff;
   assign rsp_bus.data_out = rsp_data_ff;

endmodule

// File: src/typed_slot_pool.sv
// Typed slot pool: SLOTS slots, each free or holding a 32-bit value of kind one or two.
// req_bus (sink): valid/ready transaction carrying action, kind and data_in.
//   produce stores data_in in the lowest free slot; consume takes the lowest
//   slot of the requested kind and frees it.
// rsp_bus (source): one transaction per request with status, slot, data_out.
//   Rejected requests (pool full, no entry of that kind) report slot 0, data 0.
// An accepted request goes through the queue, the back end's S_PICK and
//   S_LOAD states and the response register, where its response waits until taken.
// The back end picks the next transaction only after loading the last one's
//   response in S_LOAD, so it never works on two transactions at once.
// A 2-entry queue lets the front take up to two transactions ahead of the
//   back end; req_bus.ready drops while it is full. A stalled response holds
//   its payload until taken and keeps the back end from loading the next one.
// Reset (synchronous, active high) marks all slots free and empties the queue;
//   no clearing pass is needed.
module typed_slot_pool #(
   parameter int SLOTS = 16
) (
   input logic       clock,
   input logic       reset,
   tsp_req_if.sink   req_bus,
   tsp_rsp_if.source rsp_bus
);
   import tsp_pkg::*;

   logic         q_valid;
   logic         q_pop;
   tsp_item_type q_item;

   // front: accept, classify, queue
   tsp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item)
   );

   // back: slot search, mark update, value store, response register
   tsp_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: src/tsp_checker.sv
`include "assert_macros.svh"

module tsp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic        [tsp_pkg::STATUS_W-1:0] rsp_status,
   input logic        [tsp_pkg::SLOT_W-1:0]   rsp_slot,
   input logic signed [tsp_pkg::DATA_W-1:0]   rsp_data
);
   import tsp_pkg::*;

   // stalled response holds
   `TSP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_data), "response dropped or changed while stalled")

   // rejected transaction reports zero slot and data
   `TSP_ASSERT(a_reject_zero, clock, reset, rsp_valid && (rsp_status != STATUS_DONE) |-> (rsp_slot == '0) && (rsp_data == '0), "rejected response carries slot or data")

   // nothing comes out right after reset
   `TSP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind typed_slot_pool tsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_slot   (rsp_bus.slot),
   .rsp_data   (rsp_bus.data_out)
);

// File: test/typed_slot_pool_tb.sv
module typed_slot_pool_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsp_pkg::*;

   localparam int POOL_SLOTS  = 16;
   localparam int RAND_ITEMS  = 500;
   localparam int QUIET_ITEMS = 60;   // tail of the run with no idling on either side
   localparam int DRAIN_WAIT  = 10;   // watch after the drain for stray responses
   // Cycles with no transaction on either channel before the run is declared hung.
   // Worst correct gap: a sender gap plus a receiver stall plus the back end's
   // S_PICK and S_LOAD states, so HANG_LIMIT is well over the slowest legal run.
   localparam int HANG_LIMIT  = 2000;

   // one expected response
   typedef struct packed {
      tsp_status_type           status;
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] data;
   } pool_reply_type;

   // Tracks slot marks and values and keeps the replies still owed by the block.
   class slot_pool_scoreboard;
      tsp_mark_type      marks [POOL_SLOTS];
      logic [DATA_W-1:0] values[POOL_SLOTS];
      pool_reply_type    owed[$];
      int errors;
      int n_store, n_take, n_full, n_empty;

      function new();
         foreach (marks[i]) marks[i] = MARK_FREE;
         foreach (values[i]) values[i] = '0;
         errors  = 0;
         n_store = 0;
         n_take  = 0;
         n_full  = 0;
         n_empty = 0;
      endfunction

      // priority encoder: lowest slot with the given mark, -1 if none
      function int first_slot(input tsp_mark_type want);
         for (int i = 0; i < POOL_SLOTS; i++) begin
            if (marks[i] == want) return i;
         end
         return -1;
      endfunction

      function void note_request(input tsp_action_type act, input logic knd,
                                 input logic [DATA_W-1:0] din);
         pool_reply_type r;
         tsp_mark_type   want;
         int             idx;
         want   = knd ? MARK_KIND2 : MARK_KIND1;
         r.slot = '0;
         r.data = '0;
         if (act == ACT_PRODUCE) begin
            idx = first_slot(MARK_FREE);
            if (idx < 0) begin
               r.status = STATUS_FULL;
               n_full++;
            end else begin
               marks[idx]  = want;
               values[idx] = din;
               r.status    = STATUS_DONE;
               r.slot      = SLOT_W'(idx);
               n_store++;
            end
         end else begin
            idx = first_slot(want);
            if (idx < 0) begin
               r.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               r.data     = values[idx];
               marks[idx] = MARK_FREE;
               r.status   = STATUS_DONE;
               r.slot     = SLOT_W'(idx);
               n_take++;
            end
         end
         owed.push_back(r);
      endfunction

      function void check_response(input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] sl,
                                   input logic [DATA_W-1:0] dout);
         pool_reply_type r;
         if (owed.size() == 0) begin
            $error("response with no transaction pending: status %0d slot %0d data %h",
                   st, sl, dout);
            errors++;
            return;
         end
         r = owed.pop_front();
         if (st !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, st);
            errors++;
         end
         if (sl !== r.slot) begin
            $error("slot: expected %0d, actual %0d", r.slot, sl);
            errors++;
         end
         if (dout !== r.data) begin
            $error("data_out: expected %h, actual %h", r.data, dout);
            errors++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;      // set for the tail of the run: no gaps, no stalls
   int   idle_cycles = 0;

   slot_pool_scoreboard sb = new();

   tsp_req_if req_if();
   tsp_rsp_if rsp_if();

   typed_slot_pool #(
      .SLOTS(POOL_SLOTS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   always #1 clock = ~clock;

   // Both channels are sampled at the edge before any NBA lands, so a request and a
   // response seen at the same edge are handled in a fixed order. A response can never
   // belong to a request accepted at the same edge, as the response is registered.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(tsp_action_type'(req_if.action), req_if.kind, req_if.data_in);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.slot, rsp_if.data_out);
      end
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses owed",
                     HANG_LIMIT, sb.pending());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts between ready stretches of random length.
   initial begin
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // Drive one request transaction; returns at the edge where it is accepted, valid left high
   // so a back-to-back transaction does not drop valid in between.
   task automatic drive_req(input tsp_action_type act, input logic knd,
                            input logic [DATA_W-1:0] din);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.action  <= act;
      req_if.kind    <= knd;
      req_if.data_in <= din;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Hold the sender off until the block owes nothing. It lets the calling edge pass
   // first, so the transaction accepted at that edge is already on the scoreboard.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Random store value, with the sign and edge patterns showing up often.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int produce_pct;
      tsp_action_type act;
      logic [DATA_W-1:0] din;

      req_if.valid   <= 1'b0;
      req_if.action  <= ACT_PRODUCE;
      req_if.kind    <= 1'b0;
      req_if.data_in <= '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // take from an empty pool, both kinds
      drive_req(ACT_CONSUME, 1'b0, 32'h1234_5678);
      drive_req(ACT_CONSUME, 1'b1, 32'h8765_4321);
      // fill every slot; value extremes go in first, kinds alternate
      for (int i = 0; i < POOL_SLOTS; i++) begin
         case (i)
            0:       din = 32'h8000_0000;
            1:       din = 32'h7FFF_FFFF;
            2:       din = 32'h0000_0000;
            3:       din = 32'hFFFF_FFFF;
            4:       din = 32'hA5A5_A5A5;
            5:       din = 32'h5A5A_5A5A;
            default: din = $urandom;
         endcase
         drive_req(ACT_PRODUCE, i[0], din);
      end
      // store into a full pool, both kinds
      drive_req(ACT_PRODUCE, 1'b0, 32'hDEAD_BEEF);
      drive_req(ACT_PRODUCE, 1'b1, 32'hCAFE_F00D);
      // free the lowest of each kind, refill the hole, take it back out
      drive_req(ACT_CONSUME, 1'b1, '0);
      drive_req(ACT_CONSUME, 1'b0, '0);
      drive_req(ACT_PRODUCE, 1'b1, 32'h0F0F_0F0F);
      drive_req(ACT_CONSUME, 1'b1, '0);
      drive_req(ACT_CONSUME, 1'b1, '0);

      wait_drained();

      // --- random part ---
      // The produce bias moves in phases so the pool swings between full and empty,
      // with stretches where one kind runs out while the other is still stored.
      produce_pct = 50;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       produce_pct = 15;
               1:       produce_pct = 50;
               default: produce_pct = 85;
            endcase
         end
         if (n == RAND_ITEMS / 2) wait_drained();
         if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         act = ($urandom_range(0, 99) < produce_pct) ? ACT_PRODUCE : ACT_CONSUME;
         drive_req(act, 1'($urandom_range(0, 1)), pick_value());
      end

      // let the pipeline empty, then watch for stray responses
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d stores, %0d takes, %0d full-pool rejects, %0d no-entry rejects",
               sb.n_store, sb.n_take, sb.n_full, sb.n_empty);
      $display("with random gaps and stalls on both channels and a quiet back-to-back tail");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/tsp_pkg.sv
src/tsp_if.sv
src/tsp_front.sv
src/tsp_back.sv
src/typed_slot_pool.sv
src/tsp_checker.sv
test/typed_slot_pool_tb.sv
